// ===== hw/rtl/grps_pkg.sv =====
// ----------------------------------------------------------------------------
// grps_pkg: shared types and codes for the grid rectangle placement store
// Input and result word layouts, status, storage and kind codes.
// ----------------------------------------------------------------------------
package grps_pkg;

	typedef enum logic [1:0] {
		KIND_PLACE  = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_FREE   = 2'd2,
		KIND_FIND   = 2'd3
	} kind_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BADARG   = 3'd1;
	localparam logic [2:0] ST_BOUNDS   = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADSTORE = 3'd4;

	localparam logic [1:0] STORE_INV     = 2'd0;
	localparam logic [1:0] STORE_STASH   = 2'd1;
	localparam logic [1:0] STORE_CUBE    = 2'd2;
	localparam logic [1:0] STORE_INVALID = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  storage;
		logic [31:0] item_id;
		logic [3:0]  pos_x;
		logic [3:0]  pos_y;
		logic [4:0]  item_width;
		logic [4:0]  item_height;
	} op_word_t;

	typedef struct packed {
		logic       ok;
		logic [2:0] status;
		logic [3:0] found_x;
		logic [3:0] found_y;
	} res_word_t;

endpackage

// ===== hw/rtl/grps_ram.sv =====
// ----------------------------------------------------------------------------
// grps_ram: generic single-port RAM
// One access per cycle: an optional write and a registered read of one address.
// ----------------------------------------------------------------------------
module grps_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// ===== hw/rtl/grid_rect_placement_store.sv =====
// ----------------------------------------------------------------------------
// grid_rect_placement_store: three owner-ID grids with rectangle placement
// Sequencer scanning one RAM-backed grid cell per step.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall, word op_word_t) carries one operation:
//  place, remove, find free rectangle or find item. Output channel
//  (out_valid/out_stall, word res_word_t) returns exactly one result each.
//  One operation is worked at a time. All three grids live in one
//  single-port RAM of 1024 cells (256 per grid slot); a cell read is an
//  address state, then a registered-data state; writes go in the check state.
//  Bad argument/storage/bounds results go straight to the done state and
//  touch no grid cell. Remove and find item read the grid cell by cell.
//  Find free rectangle reads the cells of each candidate corner's rectangle
//  until one is occupied or all are empty. Place clears its own ID (one grid
//  sweep), then per rectangle cell reads it and, if a foreign ID is there,
//  sweeps the grid clearing that ID: worst case is w*h such sweeps.
//  Reset: a clearing pass zeroes all 1024 RAM cells; in_stall is high
//  until it ends. A stalled result holds in the output register; the next
//  operation is still taken and worked, then waits until that register frees.
// ----------------------------------------------------------------------------
module grid_rect_placement_store #(
	parameter int INV_COLS   = 16,
	parameter int INV_ROWS   = 8,
	parameter int STASH_COLS = 16,
	parameter int STASH_ROWS = 16,
	parameter int CUBE_COLS  = 4,
	parameter int CUBE_ROWS  = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  grps_pkg::op_word_t    in_word,
	output logic                  out_valid,
	input  logic                  out_stall,
	output grps_pkg::res_word_t   out_word
);
	import grps_pkg::*;

	localparam int AW = 10;
	localparam logic [AW-1:0] BASE_INV   = 10'd0;
	localparam logic [AW-1:0] BASE_STASH = 10'd256;
	localparam logic [AW-1:0] BASE_CUBE  = 10'd512;

	typedef enum logic [9:0] {
		S_CLEAR  = 10'b0000000001,
		S_IDLE   = 10'b0000000010,
		S_CLRRD  = 10'b0000000100,
		S_CLRCHK = 10'b0000001000,
		S_PCRD   = 10'b0000010000,
		S_PCCHK  = 10'b0000100000,
		S_FRRD   = 10'b0001000000,
		S_FRCHK  = 10'b0010000000,
		S_FDCHK  = 10'b0100000000,
		S_DONE   = 10'b1000000000
	} state_t;

	state_t      state_q;
	op_word_t    op_q;
	logic [4:0]  cols_q, rows_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] clr_q;
	logic [31:0] tgt_q;          // ID being swept out of the grid
	logic        sweep_ret_q;    // sweep returns into place loop
	logic        own_done_q;     // own-ID clear finished
	logic [3:0]  sc_q, sr_q;     // sweep cell
	logic [3:0]  pc_q, pr_q;     // place / candidate corner
	logic [4:0]  dc_q, dr_q;     // offset inside candidate
	res_word_t   res_q;
	res_word_t   out_q;
	logic        out_valid_q;

	logic          ram_we;
	logic [AW-1:0] ram_addr;
	logic [31:0]   ram_wdata, ram_rdata;

	grps_ram #(.WIDTH(32), .DEPTH(1024)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// cell address from column/row within the selected grid
	function automatic logic [AW-1:0] cell_addr(input logic [AW-1:0] b, input logic [4:0] nc,
		input logic [4:0] c, input logic [4:0] r);
		logic [9:0] p;
		p = r * nc;
		return b + AW'(p) + AW'(c);
	endfunction

	// decode of incoming op
	logic [4:0] in_cols, in_rows;
	logic [AW-1:0] in_base;
	logic in_bad_store;
	always_comb begin
		in_bad_store = 1'b0;
		unique case (in_word.storage)
			STORE_INV:   begin in_cols = 5'(INV_COLS);   in_rows = 5'(INV_ROWS);   in_base = BASE_INV; end
			STORE_STASH: begin in_cols = 5'(STASH_COLS); in_rows = 5'(STASH_ROWS); in_base = BASE_STASH; end
			STORE_CUBE:  begin in_cols = 5'(CUBE_COLS);  in_rows = 5'(CUBE_ROWS);  in_base = BASE_CUBE; end
			default: begin in_cols = 5'd0; in_rows = 5'd0; in_base = '0; in_bad_store = 1'b1; end
		endcase
	end

	logic in_badarg, in_oob;
	always_comb begin
		unique case (kind_t'(in_word.kind))
			KIND_PLACE: in_badarg = (in_word.item_id == '0) || (in_word.item_width == '0)
				|| (in_word.item_height == '0);
			KIND_FREE:  in_badarg = (in_word.item_width == '0) || (in_word.item_height == '0);
			default:    in_badarg = (in_word.item_id == '0);
		endcase
		in_oob = (6'(in_word.pos_x) + 6'(in_word.item_width) > 6'(in_cols))
			|| (6'(in_word.pos_y) + 6'(in_word.item_height) > 6'(in_rows));
	end

	// early status: arguments, then storage, then bounds for place and find free
	logic [2:0] in_status;
	always_comb begin
		priority if (in_badarg) in_status = ST_BADARG;
		else if (in_bad_store) in_status = ST_BADSTORE;
		else if (in_oob && (kind_t'(in_word.kind) == KIND_PLACE
			|| kind_t'(in_word.kind) == KIND_FREE)) in_status = ST_BOUNDS;
		else in_status = ST_OK;
	end

	// derived positions for scans
	logic [4:0] sc_nx, sr_nx;
	logic sweep_last;
	assign sc_nx = 5'(sc_q) + 5'd1;
	assign sr_nx = 5'(sr_q) + 5'd1;
	assign sweep_last = (sc_nx == cols_q) && (sr_nx == rows_q);
	logic [4:0] cand_c, cand_r;
	assign cand_c = 5'(pc_q) + dc_q;
	assign cand_r = 5'(pr_q) + dr_q;

	logic accept;
	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_word = out_q;

	// RAM port control
	always_comb begin
		ram_we = 1'b0;
		ram_wdata = '0;
		ram_addr = cell_addr(base_q, cols_q, 5'(sc_q), 5'(sr_q));
		priority case (state_q)
			S_CLEAR: begin ram_we = 1'b1; ram_addr = clr_q; end
			S_CLRCHK: if (ram_rdata == tgt_q) ram_we = 1'b1;
			S_PCRD, S_PCCHK: begin
				ram_addr = cell_addr(base_q, cols_q, 5'(pc_q), 5'(pr_q));
				if (state_q == S_PCCHK && (ram_rdata == '0 || ram_rdata == op_q.item_id)) begin
					ram_we = 1'b1; ram_wdata = op_q.item_id;
				end
			end
			S_FRRD, S_FRCHK: ram_addr = cell_addr(base_q, cols_q, cand_c, cand_r);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// output register: load from done, drop once taken
			if (state_q == S_DONE && (!out_valid_q || !out_stall)) begin
				out_q <= '{ok: (res_q.status == ST_OK), status: res_q.status,
					found_x: res_q.found_x, found_y: res_q.found_y};
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: if (accept) begin
					op_q <= in_word;
					cols_q <= in_cols; rows_q <= in_rows; base_q <= in_base;
					res_q <= '{ok: 1'b0, status: in_status, found_x: 4'd0, found_y: 4'd0};
					sc_q <= '0; sr_q <= '0;
					pc_q <= in_word.pos_x; pr_q <= in_word.pos_y;
					dc_q <= '0; dr_q <= '0;
					tgt_q <= in_word.item_id;
					sweep_ret_q <= (kind_t'(in_word.kind) == KIND_PLACE);
					own_done_q <= 1'b0;
					if (in_status != ST_OK) begin
						state_q <= S_DONE;
					end else if (kind_t'(in_word.kind) == KIND_FREE) begin
						state_q <= S_FRRD;
					end else begin
						state_q <= S_CLRRD;
					end
				end
				// sweep: read phase; find item shares it
				S_CLRRD: state_q <= (kind_t'(op_q.kind) == KIND_FIND) ? S_FDCHK : S_CLRCHK;
				S_CLRCHK: begin
					if (sweep_last) begin
						sc_q <= '0; sr_q <= '0;
						if (sweep_ret_q) begin
							if (own_done_q) begin
								// foreign ID evicted: now write the place cell
								state_q <= S_PCRD;
							end else begin
								own_done_q <= 1'b1;
								state_q <= S_PCRD;
							end
						end else state_q <= S_DONE;
					end else begin
						if (sc_nx == cols_q) begin sc_q <= '0; sr_q <= sr_q + 1'b1; end
						else sc_q <= sc_q + 1'b1;
						state_q <= S_CLRRD;
					end
				end
				S_FDCHK: begin
					if (ram_rdata == op_q.item_id) begin
						res_q.found_x <= sc_q; res_q.found_y <= sr_q; state_q <= S_DONE;
					end else if (sweep_last) begin
						res_q.status <= ST_NOTFOUND; state_q <= S_DONE;
					end else begin
						if (sc_nx == cols_q) begin sc_q <= '0; sr_q <= sr_q + 1'b1; end
						else sc_q <= sc_q + 1'b1;
						state_q <= S_CLRRD;
					end
				end
				S_PCRD: state_q <= S_PCCHK;
				S_PCCHK: begin
					if (ram_rdata != '0 && ram_rdata != op_q.item_id) begin
						tgt_q <= ram_rdata; state_q <= S_CLRRD;
					end else if (5'(pc_q) + 5'd1 == 5'(op_q.pos_x) + op_q.item_width) begin
						pc_q <= op_q.pos_x;
						if (5'(pr_q) + 5'd1 == 5'(op_q.pos_y) + op_q.item_height) state_q <= S_DONE;
						else begin pr_q <= pr_q + 1'b1; state_q <= S_PCRD; end
					end else begin
						pc_q <= pc_q + 1'b1; state_q <= S_PCRD;
					end
				end
				S_FRRD: state_q <= S_FRCHK;
				S_FRCHK: begin
					if (ram_rdata != '0) begin
						dc_q <= '0; dr_q <= '0;
						if (5'(pc_q) + op_q.item_width != cols_q) begin
							pc_q <= pc_q + 1'b1; state_q <= S_FRRD;
						end else if (5'(pr_q) + op_q.item_height != rows_q) begin
							pc_q <= '0; pr_q <= pr_q + 1'b1; state_q <= S_FRRD;
						end else begin
							res_q.status <= ST_NOTFOUND; state_q <= S_DONE;
						end
					end else if (dc_q + 5'd1 != op_q.item_width) begin
						dc_q <= dc_q + 5'd1; state_q <= S_FRRD;
					end else if (dr_q + 5'd1 != op_q.item_height) begin
						dc_q <= '0; dr_q <= dr_q + 5'd1; state_q <= S_FRRD;
					end else begin
						res_q.found_x <= pc_q; res_q.found_y <= pr_q; state_q <= S_DONE;
					end
				end
				S_DONE: if (!out_valid_q || !out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result word must have ok consistent with status
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.ok == (out_word.status == ST_OK)))
		else $error("ok flag disagrees with status");
	// a new op is taken only from idle, with the RAM clear finished
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != S_IDLE && state_q != S_CLEAR))
		else $error("accepted op did not leave idle");
	// a result shows up only on leaving the done state
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_DONE))
		else $error("result raised outside done state");
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: self-checking bench for grid_rect_placement_store
// Drives place, remove, find-free and find-item words through the valid/stall
// handshake and checks every result word against a grid model kept in the
// bench. It runs directed corner cases, then random phases with different
// sender and receiver idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import grps_pkg::*;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	op_word_t  in_word;
	logic      out_valid;
	logic      out_stall;
	res_word_t out_word;

	grid_rect_placement_store uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_word  (in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word (out_word)
	);

	// grid shapes, same as the block's defaults
	localparam int GRID_COLS [3] = '{16, 16, 4};
	localparam int GRID_ROWS [3] = '{8, 16, 4};

	// model grids: cell (col,row) at row*cols+col
	logic [31:0] grid_cells [3][256];
	res_word_t   pending_results [$];

	int idle_pct;
	int stall_pct;
	int hold_cycles;
	int words_sent;
	int words_checked;
	int mismatches;
	int fail_count;

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------------
	// grid model
	// ------------------------------------------------------------------------
	function automatic void clear_owner(int s, logic [31:0] id);
		for (int i = 0; i < GRID_COLS[s] * GRID_ROWS[s]; i++)
			if (grid_cells[s][i] == id)
				grid_cells[s][i] = '0;
	endfunction

	function automatic bit rect_is_empty(int s, int c0, int r0, int w, int h);
		for (int r = r0; r < r0 + h; r++)
			for (int c = c0; c < c0 + w; c++)
				if (grid_cells[s][r * GRID_COLS[s] + c] != '0)
					return 1'b0;
		return 1'b1;
	endfunction

	// apply one operation to the model grids and return its result word
	function automatic res_word_t apply_grid_op(op_word_t op);
		res_word_t   res;
		int          s, cols, rows, px, py, w, h;
		logic [31:0] id, old;
		bit          found;

		res = '0;
		res.status = ST_OK;
		s = op.storage;
		id = op.item_id;
		px = op.pos_x;
		py = op.pos_y;
		w = op.item_width;
		h = op.item_height;
		found = 1'b0;
		if ((op.kind == KIND_PLACE && (id == 0 || w == 0 || h == 0)) ||
		    ((op.kind == KIND_REMOVE || op.kind == KIND_FIND) && id == 0) ||
		    (op.kind == KIND_FREE && (w == 0 || h == 0))) begin
			res.status = ST_BADARG;
		end else if (s > 2) begin
			res.status = ST_BADSTORE;
		end else begin
			cols = GRID_COLS[s];
			rows = GRID_ROWS[s];
			case (op.kind)
				KIND_PLACE: begin
					if (px + w > cols || py + h > rows) begin
						res.status = ST_BOUNDS;
					end else begin
						clear_owner(s, id);
						for (int r = py; r < py + h; r++)
							for (int c = px; c < px + w; c++) begin
								old = grid_cells[s][r * cols + c];
								if (old != 0 && old != id)
									clear_owner(s, old);
								grid_cells[s][r * cols + c] = id;
							end
					end
				end
				KIND_REMOVE: begin
					clear_owner(s, id);
				end
				KIND_FREE: begin
					if (px + w > cols || py + h > rows) begin
						res.status = ST_BOUNDS;
					end else begin
						// first row starts at pos_x, later rows at column 0
						for (int r = py; r + h <= rows && !found; r++)
							for (int c = (r == py) ? px : 0; c + w <= cols && !found; c++)
								if (rect_is_empty(s, c, r, w, h)) begin
									res.found_x = 4'(c);
									res.found_y = 4'(r);
									found = 1'b1;
								end
						if (!found)
							res.status = ST_NOTFOUND;
					end
				end
				default: begin
					for (int r = 0; r < rows && !found; r++)
						for (int c = 0; c < cols && !found; c++)
							if (grid_cells[s][r * cols + c] == id) begin
								res.found_x = 4'(c);
								res.found_y = 4'(r);
								found = 1'b1;
							end
					if (!found)
						res.status = ST_NOTFOUND;
				end
			endcase
		end
		res.ok = (res.status == ST_OK);
		return res;
	endfunction

	// ------------------------------------------------------------------------
	// sender: optional idle gap, then hold the word until accepted
	// ------------------------------------------------------------------------
	task automatic send_word(op_word_t op);
		bit taken;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		in_word <= op;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pending_results.push_back(apply_grid_op(op));
		words_sent++;
	endtask

	function automatic op_word_t make_word(logic [1:0] kind, logic [1:0] storage,
	                                       logic [31:0] id, int px, int py, int w, int h);
		op_word_t op;
		op.kind = kind;
		op.storage = storage;
		op.item_id = id;
		op.pos_x = 4'(px);
		op.pos_y = 4'(py);
		op.item_width = 5'(w);
		op.item_height = 5'(h);
		return op;
	endfunction

	// random word: small IDs so rectangles collide, mostly small sizes
	function automatic op_word_t random_word();
		op_word_t op;
		int       pick;
		op = '0;
		pick = $urandom_range(99);
		op.kind = (pick < 40) ? KIND_PLACE : (pick < 55) ? KIND_REMOVE :
		          (pick < 80) ? KIND_FREE : KIND_FIND;
		op.storage = ($urandom_range(19) == 0) ? STORE_INVALID : 2'($urandom_range(2));
		pick = $urandom_range(99);
		op.item_id = (pick < 3) ? 32'd0 : (pick < 10) ? $urandom() :
		             (pick < 12) ? 32'hFFFF_FFFF : $urandom_range(8, 1);
		op.pos_x = 4'($urandom_range(15));
		op.pos_y = 4'($urandom_range(15));
		// positions near the origin keep most requests in bounds
		if ($urandom_range(1)) begin
			op.pos_x = 4'($urandom_range(3));
			op.pos_y = 4'($urandom_range(3));
		end
		pick = $urandom_range(99);
		op.item_width = (pick < 3) ? 5'd0 : (pick < 6) ? 5'($urandom_range(31)) :
		                (pick < 12) ? 5'($urandom_range(16, 1)) : 5'($urandom_range(4, 1));
		pick = $urandom_range(99);
		op.item_height = (pick < 3) ? 5'd0 : (pick < 6) ? 5'($urandom_range(31)) :
		                 (pick < 12) ? 5'($urandom_range(16, 1)) : 5'($urandom_range(4, 1));
		return op;
	endfunction

	// ------------------------------------------------------------------------
	// receiver stall: random by phase, or a counted hold-off
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// result checker: a word seen here is taken at the next rising edge
	initial begin
		res_word_t want;
		forever begin
			@(negedge clk);
			if (arst_n && out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					fail_count++;
					if (mismatches++ < 10)
						$display("unexpected result word %h", out_word);
				end else begin
					want = pending_results.pop_front();
					words_checked++;
					if (out_word.ok !== want.ok || out_word.status !== want.status ||
					    out_word.found_x !== want.found_x ||
					    out_word.found_y !== want.found_y) begin
						fail_count++;
						if (mismatches++ < 10)
							$display("result %0d: want ok=%0d st=%0d x=%0d y=%0d, got ok=%0d st=%0d x=%0d y=%0d",
							         words_checked, want.ok, want.status, want.found_x,
							         want.found_y, out_word.ok, out_word.status,
							         out_word.found_x, out_word.found_y);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------
	task automatic test_directed();
		idle_pct = 0;
		stall_pct = 0;
		// bad arguments for every kind
		send_word(make_word(KIND_PLACE, STORE_INV, 32'd0, 0, 0, 1, 1));
		send_word(make_word(KIND_PLACE, STORE_INV, 32'd5, 0, 0, 0, 1));
		send_word(make_word(KIND_PLACE, STORE_INV, 32'd5, 0, 0, 1, 0));
		send_word(make_word(KIND_REMOVE, STORE_STASH, 32'd0, 0, 0, 1, 1));
		send_word(make_word(KIND_FREE, STORE_CUBE, 32'd0, 0, 0, 0, 31));
		send_word(make_word(KIND_FIND, STORE_CUBE, 32'd0, 15, 15, 31, 31));
		// invalid storage for every kind
		send_word(make_word(KIND_PLACE, STORE_INVALID, 32'd1, 0, 0, 1, 1));
		send_word(make_word(KIND_REMOVE, STORE_INVALID, 32'd1, 0, 0, 1, 1));
		send_word(make_word(KIND_FREE, STORE_INVALID, 32'd0, 0, 0, 1, 1));
		send_word(make_word(KIND_FIND, STORE_INVALID, 32'd1, 0, 0, 1, 1));
		// out of bounds, then a full-grid place with the largest ID
		send_word(make_word(KIND_PLACE, STORE_INV, 32'd1, 15, 0, 2, 1));
		send_word(make_word(KIND_FREE, STORE_CUBE, 32'd0, 0, 3, 1, 2));
		send_word(make_word(KIND_PLACE, STORE_CUBE, 32'hFFFF_FFFF, 0, 0, 4, 4));
		send_word(make_word(KIND_FREE, STORE_CUBE, 32'd0, 0, 0, 1, 1));
		// overlap evicts the big ID, re-place moves ID 2
		send_word(make_word(KIND_PLACE, STORE_CUBE, 32'd2, 3, 3, 1, 1));
		send_word(make_word(KIND_FIND, STORE_CUBE, 32'hFFFF_FFFF, 0, 0, 1, 1));
		send_word(make_word(KIND_PLACE, STORE_CUBE, 32'd2, 0, 0, 2, 2));
		send_word(make_word(KIND_FIND, STORE_CUBE, 32'd2, 0, 0, 1, 1));
		// search wrap: start late on a row, fit only on a later row
		send_word(make_word(KIND_PLACE, STORE_INV, 32'd3, 14, 0, 2, 1));
		send_word(make_word(KIND_FREE, STORE_INV, 32'd0, 14, 0, 2, 2));
		send_word(make_word(KIND_PLACE, STORE_STASH, 32'd7, 0, 0, 16, 16));
		send_word(make_word(KIND_FIND, STORE_STASH, 32'd7, 15, 15, 1, 1));
		send_word(make_word(KIND_REMOVE, STORE_STASH, 32'd7, 0, 0, 1, 1));
		send_word(make_word(KIND_REMOVE, STORE_STASH, 32'd9, 0, 0, 1, 1));
		send_word(make_word(KIND_FIND, STORE_INV, 32'd9, 0, 0, 1, 1));
	endtask

	task automatic test_random(int count, int idle, int stall);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_word(random_word());
	endtask

	// receiver holds off long while the sender keeps offering words
	task automatic test_backpressure();
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 3000;
		repeat (40)
			send_word(random_word());
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_word = '0;
		out_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		hold_cycles = 0;
		words_sent = 0;
		words_checked = 0;
		mismatches = 0;
		fail_count = 0;
		for (int s = 0; s < 3; s++)
			for (int i = 0; i < 256; i++)
				grid_cells[s][i] = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random(500, 0, 0);
		test_random(500, 78, 0);
		test_random(500, 0, 78);
		test_random(500, 25, 25);
		test_backpressure();

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("sent %0d operation words, checked %0d result words, %0d mismatches",
		         words_sent, words_checked, mismatches);
		$display("covered all kinds and storages, error codes, evictions and search wrap");
		if (fail_count == 0 && pending_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000_000;
		$display("timeout with %0d results outstanding", pending_results.size());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule
